// ===== rtl/triangle_tangent_frame_defines.svh =====
// Assertion macros for the triangle tangent frame block.
// Each one expects clk and rst_n in the scope where it is used.
`ifndef TRIANGLE_TANGENT_FRAME_DEFINES_SVH
`define TRIANGLE_TANGENT_FRAME_DEFINES_SVH

`ifndef SYNTHESIS
`define TTF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tangent frame check failed (same cycle)");
`define TTF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tangent frame check failed (next cycle)");
`else
`define TTF_ASSERT_IMP(lbl, ante, cons)
`define TTF_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/ttf_pkg.sv =====
`timescale 1ns / 1ps
package ttf_pkg;

  localparam int COORD_BITS    = 16;
  localparam int UV_BITS       = 16;
  localparam int OUT_FRAC_BITS = 14;
  localparam int PRESCALE_BITS = 24;

  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int RAW_W  = PROD_W + 1;
  localparam int MAG_W  = RAW_W - 1;
  localparam int OUT_W  = 16;
  localparam int CFG_W  = 16;
  localparam int IDX_W  = 8;

  typedef logic [MAG_W-1:0] mag_t;
  typedef logic signed [OUT_W-1:0] comp_t;

  typedef enum logic [IDX_W-1:0] {
    CFG_MIN_ABS_DET   = 8'd0,
    CFG_MIN_LENGTH_SQ = 8'd1
  } cfg_idx_t;

  typedef struct packed {
    logic valid;
    logic det_ok;
  } tag_t;

  typedef struct packed {
    tag_t            tag;
    logic            ok;
    logic [2:0][OUT_W-1:0] comp;
  } norm_res_t;

endpackage

// ===== rtl/ttf_norm.sv =====
`timescale 1ns / 1ps
module ttf_norm (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic [ttf_pkg::CFG_W-1:0]      min_len_sq,
  input  ttf_pkg::tag_t                  tag_in,
  input  logic [2:0][ttf_pkg::MAG_W-1:0] mag_in,
  input  logic [2:0]                     neg_in,
  output ttf_pkg::norm_res_t             res
);
  import ttf_pkg::*;

  localparam int NS     = OUT_FRAC_BITS + 1;
  localparam int SH_MAX = MAG_W - PRESCALE_BITS;
  localparam int SH_W   = $clog2(SH_MAX + 1);
  localparam int SQ_W   = 2 * PRESCALE_BITS;
  localparam int S_W    = SQ_W + 2;
  localparam int R_W    = SQ_W + 2 * OUT_FRAC_BITS + 2;
  localparam int P_W    = R_W + 8;
  localparam int L2_W   = 18;

  // stage A: small-vector length check and max magnitude
  logic [L2_W-1:0] len2_c;
  logic            small_c;
  logic            fail_c;
  mag_t            m_c;

  always_comb begin
    len2_c = '0;
    small_c = 1'b1;
    m_c = '0;
    for (int i = 0; i < 3; i++) begin
      len2_c = len2_c + L2_W'({8'd0, mag_in[i][7:0]} * {8'd0, mag_in[i][7:0]});
      if (mag_in[i][MAG_W-1:8] != '0) begin
        small_c = 1'b0;
      end
      if (mag_in[i] > m_c) begin
        m_c = mag_in[i];
      end
    end
    fail_c = small_c && ((len2_c == '0) || (len2_c < L2_W'(min_len_sq)));
  end

  logic [2:0][MAG_W-1:0] mag_a_r;
  logic [2:0]            neg_a_r;
  logic                  fail_a_r;
  mag_t                  m_a_r;
  tag_t                  tag_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_a_r <= '0;
    end else if (en) begin
      tag_a_r <= tag_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_a_r  <= mag_in;
      neg_a_r  <= neg_in;
      fail_a_r <= fail_c;
      m_a_r    <= m_c;
    end
  end

  // stage B: prescale into the 24-bit range
  logic [SH_W-1:0]                 sh_c;
  logic [2:0][PRESCALE_BITS-1:0]   mag_b_c;

  always_comb begin
    sh_c = '0;
    for (int s = 1; s <= SH_MAX; s++) begin
      if (m_a_r[PRESCALE_BITS+s-1]) begin
        sh_c = SH_W'(s);
      end
    end
    for (int i = 0; i < 3; i++) begin
      mag_b_c[i] = PRESCALE_BITS'(mag_a_r[i] >> sh_c);
    end
  end

  logic [2:0][PRESCALE_BITS-1:0] mag_b_r;
  logic [2:0]                    neg_b_r;
  logic                          fail_b_r;
  tag_t                          tag_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_b_r <= '0;
    end else if (en) begin
      tag_b_r <= tag_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_b_r  <= mag_b_c;
      neg_b_r  <= neg_a_r;
      fail_b_r <= fail_a_r;
    end
  end

  // stage C: squares
  logic [2:0][SQ_W-1:0] sq_c_r;
  logic [2:0]           neg_c_r;
  logic                 fail_c_r;
  tag_t                 tag_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_c_r <= '0;
    end else if (en) begin
      tag_c_r <= tag_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq_c_r[i] <= SQ_W'({{PRESCALE_BITS{1'b0}}, mag_b_r[i]} *
                           {{PRESCALE_BITS{1'b0}}, mag_b_r[i]});
      end
      neg_c_r  <= neg_b_r;
      fail_c_r <= fail_b_r;
    end
  end

  // stage D and search: q is grown one bit a stage, with P = (2q-1)^2 S and U = (2q-1) S
  logic [S_W-1:0]                    s_r    [NS+1];
  logic [2:0][R_W-1:0]               r_r    [NS+1];
  logic signed [2:0][P_W-1:0]        p_r    [NS+1];
  logic signed [2:0][P_W-1:0]        u_r    [NS+1];
  logic [2:0][NS-1:0]                q_r    [NS+1];
  logic [2:0]                        neg_r  [NS+1];
  logic                              fail_r [NS+1];
  tag_t                              tag_r  [NS+1];

  logic [S_W-1:0] s_sum_c;
  assign s_sum_c = S_W'(sq_c_r[0]) + S_W'(sq_c_r[1]) + S_W'(sq_c_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r[0] <= '0;
    end else if (en) begin
      tag_r[0] <= tag_c_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r[0] <= s_sum_c;
      for (int i = 0; i < 3; i++) begin
        r_r[0][i] <= {sq_c_r[i], {(R_W-SQ_W){1'b0}}};
        p_r[0][i] <= $signed(P_W'(s_sum_c));
        u_r[0][i] <= -$signed(P_W'(s_sum_c));
        q_r[0][i] <= '0;
      end
      neg_r[0]  <= neg_c_r;
      fail_r[0] <= fail_c_r;
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_step
    localparam int B = NS - 1 - k;
    logic signed [2:0][P_W-1:0] newp_c;
    logic [2:0]                 take_c;
    logic signed [P_W-1:0]      s_ext_c;

    always_comb begin
      s_ext_c = $signed(P_W'(s_r[k]));
      for (int i = 0; i < 3; i++) begin
        newp_c[i] = p_r[k][i] + (u_r[k][i] <<< (B + 2)) + (s_ext_c <<< (2 * B + 2));
        take_c[i] = newp_c[i] <= $signed(P_W'(r_r[k][i]));
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_r[k+1] <= '0;
      end else if (en) begin
        tag_r[k+1] <= tag_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_r[k+1]    <= s_r[k];
        r_r[k+1]    <= r_r[k];
        neg_r[k+1]  <= neg_r[k];
        fail_r[k+1] <= fail_r[k];
        for (int i = 0; i < 3; i++) begin
          if (take_c[i]) begin
            p_r[k+1][i]    <= newp_c[i];
            u_r[k+1][i]    <= u_r[k][i] + (s_ext_c <<< (B + 1));
            q_r[k+1][i]    <= q_r[k][i] | NS'(1 << B);
          end else begin
            p_r[k+1][i]    <= p_r[k][i];
            u_r[k+1][i]    <= u_r[k][i];
            q_r[k+1][i]    <= q_r[k][i];
          end
        end
      end
    end
  end

  always_comb begin
    res.tag = tag_r[NS];
    res.ok  = !fail_r[NS];
    for (int i = 0; i < 3; i++) begin
      if (neg_r[NS][i]) begin
        res.comp[i] = OUT_W'(-{1'b0, q_r[NS][i]});
      end else begin
        res.comp[i] = OUT_W'({1'b0, q_r[NS][i]});
      end
    end
  end

endmodule

// ===== rtl/triangle_tangent_frame.sv =====
// channel | direction | handshake             | payload
// in      | input     | in_valid / in_ready   | three positions, three uv pairs
// out     | output    | out_valid / out_ready | tangent, bitangent, frame_valid
// cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One triangle per cycle, back to back, unless the output stalls; 24 register
// stages. Depth is set mostly by the 15-step restoring search for each
// normalized component.
// Synchronous active-low reset clears the valid bits and loads both
// thresholds with 1. A stalled output freezes the whole pipeline.
`timescale 1ns / 1ps
`include "triangle_tangent_frame_defines.svh"
module triangle_tangent_frame (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [47:0]                   in_vertex0_pos,
  input  logic [47:0]                   in_vertex1_pos,
  input  logic [47:0]                   in_vertex2_pos,
  input  logic [31:0]                   in_vertex0_uv,
  input  logic [31:0]                   in_vertex1_uv,
  input  logic [31:0]                   in_vertex2_uv,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [15:0]            out_tangent_x,
  output logic signed [15:0]            out_tangent_y,
  output logic signed [15:0]            out_tangent_z,
  output logic signed [15:0]            out_bitangent_x,
  output logic signed [15:0]            out_bitangent_y,
  output logic signed [15:0]            out_bitangent_z,
  output logic                          out_frame_valid,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ttf_pkg::IDX_W-1:0]     cfg_index,
  input  logic [ttf_pkg::CFG_W-1:0]     cfg_data
);
  import ttf_pkg::*;

  localparam int DET_MAG_W = RAW_W - 1;

  logic en;
  logic out_valid_r;

  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;

  logic [CFG_W-1:0] min_abs_det_r;
  logic [CFG_W-1:0] min_len_sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_abs_det_r <= CFG_W'(1);
      min_len_sq_r  <= CFG_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MIN_ABS_DET:   min_abs_det_r <= cfg_data;
        CFG_MIN_LENGTH_SQ: min_len_sq_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 1: edges and uv deltas
  logic signed [2:0][COORD_BITS-1:0] p0_c, p1_c, p2_c;
  logic signed [UV_BITS-1:0]         u0_c, v0_c, u1_c, v1_c, u2_c, v2_c;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      p0_c[j] = in_vertex0_pos[j*COORD_BITS +: COORD_BITS];
      p1_c[j] = in_vertex1_pos[j*COORD_BITS +: COORD_BITS];
      p2_c[j] = in_vertex2_pos[j*COORD_BITS +: COORD_BITS];
    end
    u0_c = in_vertex0_uv[UV_BITS-1:0];
    v0_c = in_vertex0_uv[2*UV_BITS-1:UV_BITS];
    u1_c = in_vertex1_uv[UV_BITS-1:0];
    v1_c = in_vertex1_uv[2*UV_BITS-1:UV_BITS];
    u2_c = in_vertex2_uv[UV_BITS-1:0];
    v2_c = in_vertex2_uv[2*UV_BITS-1:UV_BITS];
  end

  logic                              v1_r;
  logic signed [2:0][DIFF_W-1:0]     e1_r, e2_r;
  logic signed [DIFF_W-1:0]          du1_r, dv1_r, du2_r, dv2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        e1_r[j] <= DIFF_W'($signed(p1_c[j])) - DIFF_W'($signed(p0_c[j]));
        e2_r[j] <= DIFF_W'($signed(p2_c[j])) - DIFF_W'($signed(p0_c[j]));
      end
      du1_r <= DIFF_W'(u1_c) - DIFF_W'(u0_c);
      dv1_r <= DIFF_W'(v1_c) - DIFF_W'(v0_c);
      du2_r <= DIFF_W'(u2_c) - DIFF_W'(u0_c);
      dv2_r <= DIFF_W'(v2_c) - DIFF_W'(v0_c);
    end
  end

  // stage 2: products
  logic                          v2_r;
  logic signed [PROD_W-1:0]      pd_a_r, pd_b_r;
  logic signed [2:0][PROD_W-1:0] pt_a_r, pt_b_r, pb_a_r, pb_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pd_a_r <= PROD_W'(du1_r * dv2_r);
      pd_b_r <= PROD_W'(du2_r * dv1_r);
      for (int j = 0; j < 3; j++) begin
        pt_a_r[j] <= PROD_W'($signed(e1_r[j]) * dv2_r);
        pt_b_r[j] <= PROD_W'($signed(e2_r[j]) * dv1_r);
        pb_a_r[j] <= PROD_W'($signed(e2_r[j]) * du1_r);
        pb_b_r[j] <= PROD_W'($signed(e1_r[j]) * du2_r);
      end
    end
  end

  // stage 3: determinant and raw vectors
  logic                         v3_r;
  logic signed [RAW_W-1:0]      det_r;
  logic signed [2:0][RAW_W-1:0] tr_r, br_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det_r <= RAW_W'(pd_a_r) - RAW_W'(pd_b_r);
      for (int j = 0; j < 3; j++) begin
        tr_r[j] <= RAW_W'($signed(pt_a_r[j])) - RAW_W'($signed(pt_b_r[j]));
        br_r[j] <= RAW_W'($signed(pb_a_r[j])) - RAW_W'($signed(pb_b_r[j]));
      end
    end
  end

  // stage 4: determinant test, magnitudes and signs
  logic [DET_MAG_W-1:0]  adet_c;
  logic [2:0][MAG_W-1:0] tmag_c, bmag_c;
  logic [2:0]            tneg_c, bneg_c;

  always_comb begin
    adet_c = det_r[RAW_W-1] ? DET_MAG_W'(-det_r) : DET_MAG_W'(det_r);
    for (int j = 0; j < 3; j++) begin
      tmag_c[j] = tr_r[j][RAW_W-1] ? MAG_W'(-tr_r[j]) : MAG_W'(tr_r[j]);
      bmag_c[j] = br_r[j][RAW_W-1] ? MAG_W'(-br_r[j]) : MAG_W'(br_r[j]);
      tneg_c[j] = tr_r[j][RAW_W-1] ^ det_r[RAW_W-1];
      bneg_c[j] = br_r[j][RAW_W-1] ^ det_r[RAW_W-1];
    end
  end

  tag_t                  tag4_r;
  logic [2:0][MAG_W-1:0] tmag_r, bmag_r;
  logic [2:0]            tneg_r, bneg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag4_r <= '0;
    end else if (en) begin
      tag4_r.valid  <= v3_r;
      tag4_r.det_ok <= (det_r != '0) && (adet_c >= DET_MAG_W'(min_abs_det_r));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tmag_r <= tmag_c;
      bmag_r <= bmag_c;
      tneg_r <= tneg_c;
      bneg_r <= bneg_c;
    end
  end

  norm_res_t tres, bres;

  ttf_norm u_norm_t (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .min_len_sq (min_len_sq_r),
    .tag_in     (tag4_r),
    .mag_in     (tmag_r),
    .neg_in     (tneg_r),
    .res        (tres)
  );

  ttf_norm u_norm_b (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .min_len_sq (min_len_sq_r),
    .tag_in     (tag4_r),
    .mag_in     (bmag_r),
    .neg_in     (bneg_r),
    .res        (bres)
  );

  // output word
  logic [2:0][OUT_W-1:0] tan_r, bit_r;
  logic                  fv_r;
  logic                  t_keep_c, b_keep_c;

  assign t_keep_c = tres.tag.det_ok && tres.ok;
  assign b_keep_c = tres.tag.det_ok && bres.ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= tres.tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tan_r <= t_keep_c ? tres.comp : '0;
      bit_r <= b_keep_c ? bres.comp : '0;
      fv_r  <= t_keep_c && b_keep_c;
    end
  end

  assign out_tangent_x   = tan_r[0];
  assign out_tangent_y   = tan_r[1];
  assign out_tangent_z   = tan_r[2];
  assign out_bitangent_x = bit_r[0];
  assign out_bitangent_y = bit_r[1];
  assign out_bitangent_z = bit_r[2];
  assign out_frame_valid = fv_r;

  `TTF_ASSERT_NXT(a_enter, in_valid && in_ready, v1_r)
  `TTF_ASSERT_IMP(a_tan_nonzero, out_valid_r && fv_r, |tan_r)
  `TTF_ASSERT_IMP(a_bit_nonzero, out_valid_r && fv_r, |bit_r)
  `TTF_ASSERT_IMP(a_tan_range, out_valid_r, (out_tangent_x <= 16'sd16384) && (out_tangent_x >= -16'sd16384))

endmodule

// ===== bench/tb_triangle_tangent_frame.sv =====
`timescale 1ns / 1ps
module tb_triangle_tangent_frame;
  import ttf_pkg::*;

  typedef struct {
    logic [47:0] p0, p1, p2;
    logic [31:0] uv0, uv1, uv2;
  } tri_t;

  typedef struct {
    logic [15:0] t[3];
    logic [15:0] b[3];
    logic        fv;
  } frame_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [47:0] in_vertex0_pos = '0, in_vertex1_pos = '0, in_vertex2_pos = '0;
  logic [31:0] in_vertex0_uv = '0, in_vertex1_uv = '0, in_vertex2_uv = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] out_tangent_x, out_tangent_y, out_tangent_z;
  logic signed [15:0] out_bitangent_x, out_bitangent_y, out_bitangent_z;
  logic out_frame_valid;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  tri_t   tri_pending[$];
  frame_t frame_expected[$];
  logic [15:0] min_det_cur = 16'd1;
  logic [15:0] min_len_cur = 16'd1;
  int errors = 0;
  int in_gap = 0;
  int out_gap = 0;
  bit no_idle = 1'b0;
  int long_hold_req = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  triangle_tangent_frame u_dut (.*);

  function automatic int idle_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic longint comp(logic [47:0] w, int j);
    logic signed [15:0] v;
    v = w[16*j +: 16];
    return longint'(v);
  endfunction

  // rounded a * 2^14 / sqrt(s)
  function automatic logic [15:0] unit_mag(longint unsigned a, longint unsigned s);
    logic [127:0] rhs, lhs, aa, tt;
    longint unsigned lo, hi, mid;
    aa = 128'(2 * a);
    rhs = (aa * aa) << (2 * OUT_FRAC_BITS);
    lo = 0;
    hi = 64'd1 << OUT_FRAC_BITS;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      tt = 128'(2 * mid - 1);
      lhs = tt * tt * 128'(s);
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return 16'(lo);
  endfunction

  function automatic bit normalize(input longint r[3], input logic [15:0] min_len,
                                   output logic [15:0] c[3]);
    longint unsigned mag[3], m, s, len2;
    bit neg[3];
    int sh;
    logic [15:0] q;
    m = 0;
    s = 0;
    sh = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = r[i] < 0;
      mag[i] = neg[i] ? -r[i] : r[i];
      if (mag[i] > m) m = mag[i];
      c[i] = '0;
    end
    if (m < 256) begin
      len2 = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
      if (len2 == 0 || len2 < min_len) return 1'b0;
    end
    while ((m >> sh) >= (64'd1 << PRESCALE_BITS)) sh++;
    for (int i = 0; i < 3; i++) begin
      mag[i] = mag[i] >> sh;
      s += mag[i] * mag[i];
    end
    for (int i = 0; i < 3; i++) begin
      q = unit_mag(mag[i], s);
      c[i] = neg[i] ? -q : q;
    end
    return 1'b1;
  endfunction

  function automatic frame_t tangent_frame(tri_t x, logic [15:0] min_det,
                                           logic [15:0] min_len);
    frame_t f;
    longint du1, dv1, du2, dv2, det, adet;
    longint e1, e2;
    longint tr[3], br[3];
    logic [15:0] c[3];
    bit ok_t, ok_b;
    for (int i = 0; i < 3; i++) begin
      f.t[i] = '0;
      f.b[i] = '0;
    end
    f.fv = 1'b0;
    du1 = comp(x.uv1, 0) - comp(x.uv0, 0);
    dv1 = comp(x.uv1, 1) - comp(x.uv0, 1);
    du2 = comp(x.uv2, 0) - comp(x.uv0, 0);
    dv2 = comp(x.uv2, 1) - comp(x.uv0, 1);
    det = du1 * dv2 - du2 * dv1;
    adet = det < 0 ? -det : det;
    if (det == 0 || adet < min_det) return f;
    for (int j = 0; j < 3; j++) begin
      e1 = comp(x.p1, j) - comp(x.p0, j);
      e2 = comp(x.p2, j) - comp(x.p0, j);
      tr[j] = e1 * dv2 - e2 * dv1;
      br[j] = e2 * du1 - e1 * du2;
      if (det < 0) begin
        tr[j] = -tr[j];
        br[j] = -br[j];
      end
    end
    ok_t = normalize(tr, min_len, c);
    f.t = c;
    ok_b = normalize(br, min_len, c);
    f.b = c;
    f.fv = ok_t && ok_b;
    return f;
  endfunction

  function automatic logic [47:0] offset_pos(logic [47:0] base, int span);
    logic [47:0] r;
    for (int j = 0; j < 3; j++)
      r[16*j +: 16] = base[16*j +: 16] + 16'($signed($urandom_range(0, 2 * span)) - span);
    return r;
  endfunction

  function automatic logic [31:0] offset_uv(logic [31:0] base, int span);
    logic [31:0] r;
    for (int j = 0; j < 2; j++)
      r[16*j +: 16] = base[16*j +: 16] + 16'($signed($urandom_range(0, 2 * span)) - span);
    return r;
  endfunction

  function automatic tri_t random_tri();
    tri_t x;
    int mode, ps, us;
    mode = $urandom_range(0, 9);
    x.p0 = 48'({$urandom(), $urandom()});
    x.uv0 = $urandom();
    case (mode)
      0, 1: begin
        x.p1 = 48'({$urandom(), $urandom()});
        x.p2 = 48'({$urandom(), $urandom()});
        x.uv1 = $urandom();
        x.uv2 = $urandom();
        return x;
      end
      2, 3: begin ps = 3; us = 3; end
      4: begin ps = 40; us = 6; end
      5: begin ps = 2000; us = 20; end
      default: begin ps = 4000; us = 3000; end
    endcase
    x.p1 = offset_pos(x.p0, ps);
    x.p2 = offset_pos(x.p0, ps);
    x.uv1 = offset_uv(x.uv0, us);
    x.uv2 = offset_uv(x.uv0, us);
    if ($urandom_range(0, 19) == 0) x.uv2 = x.uv1;
    if ($urandom_range(0, 19) == 0) x.p2 = x.p1;
    return x;
  endfunction

  function automatic tri_t mk(logic [47:0] a, b, c, logic [31:0] u0, u1, u2);
    tri_t x;
    x.p0 = a;
    x.p1 = b;
    x.p2 = c;
    x.uv0 = u0;
    x.uv1 = u1;
    x.uv2 = u2;
    return x;
  endfunction

  task automatic add_tri(tri_t x);
    tri_pending.insert(tri_pending.size(), x);
  endtask

  // feed words; predict each one as it is taken
  always @(posedge clk) begin
    tri_t x;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        x = mk(in_vertex0_pos, in_vertex1_pos, in_vertex2_pos,
               in_vertex0_uv, in_vertex1_uv, in_vertex2_uv);
        frame_expected.insert(frame_expected.size(),
                              tangent_frame(x, min_det_cur, min_len_cur));
      end
      if (in_valid && !in_ready) begin
        // hold
      end else if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap--;
      end else if (tri_pending.size() > 0) begin
        x = tri_pending.pop_front();
        in_vertex0_pos <= x.p0;
        in_vertex1_pos <= x.p1;
        in_vertex2_pos <= x.p2;
        in_vertex0_uv <= x.uv0;
        in_vertex1_uv <= x.uv1;
        in_vertex2_uv <= x.uv2;
        in_valid <= 1'b1;
        in_gap = idle_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (long_hold_req > 0) begin
      out_ready <= 1'b0;
      out_gap = long_hold_req;
      long_hold_req = 0;
    end else if (out_gap > 0) begin
      out_ready <= 1'b0;
      out_gap--;
    end else begin
      out_ready <= 1'b1;
      out_gap = idle_len();
    end
  end

  always @(posedge clk) begin
    frame_t e;
    logic [15:0] got[6];
    if (rst_n && out_valid && out_ready) begin
      if (frame_expected.size() == 0) begin
        $display("%0t: unexpected frame word", $time);
        errors++;
      end else begin
        e = frame_expected.pop_front();
        got = '{out_tangent_x, out_tangent_y, out_tangent_z,
                out_bitangent_x, out_bitangent_y, out_bitangent_z};
        for (int i = 0; i < 3; i++) begin
          if (got[i] !== e.t[i]) begin
            $display("%0t: tangent[%0d] expected %h got %h", $time, i, e.t[i], got[i]);
            errors++;
          end
          if (got[3+i] !== e.b[i]) begin
            $display("%0t: bitangent[%0d] expected %h got %h", $time, i, e.b[i], got[3+i]);
            errors++;
          end
        end
        if (out_frame_valid !== e.fv) begin
          $display("%0t: frame_valid expected %b got %b", $time, e.fv, out_frame_valid);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_MIN_ABS_DET) min_det_cur = val;
    else min_len_cur = val;
  endtask

  task automatic drain();
    do @(negedge clk);
    while (tri_pending.size() != 0 || in_valid || frame_expected.size() != 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic random_phase(int n, bit calm);
    no_idle = calm;
    repeat (n) add_tri(random_tri());
    drain();
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset thresholds
    add_tri(mk('0, '0, '0, '0, '0, '0));
    add_tri(mk(48'h0000_0000_0000, 48'h0000_0000_0100, 48'h0000_0100_0000,
               32'h0000_0000, 32'h0000_1000, 32'h1000_0000));
    add_tri(mk(48'h0000_0000_0000, 48'h0000_0000_0100, 48'h0000_0100_0000,
               32'h0000_0000, 32'h1000_0000, 32'h0000_1000));
    add_tri(mk(48'h8000_8000_8000, 48'h7fff_7fff_7fff, 48'h8000_7fff_8000,
               32'h8000_8000, 32'h7fff_7fff, 32'h8000_7fff));
    add_tri(mk(48'h7fff_7fff_7fff, 48'h8000_8000_8000, 48'h7fff_8000_8000,
               32'h7fff_7fff, 32'h8000_8000, 32'h7fff_8000));
    add_tri(mk(48'h1234_5678_9abc, 48'h1234_5678_9abc, 48'h1234_5678_9abc,
               32'h0000_0000, 32'h0000_0001, 32'h0001_0000));
    add_tri(mk(48'h0000_0000_0000, 48'h0000_0000_0001, 48'h0000_0001_0000,
               32'h0000_0000, 32'h0000_0001, 32'h0001_0000));
    add_tri(mk(48'h0000_0000_0000, 48'h0000_0000_0100, 48'h0000_0000_0200,
               32'h0000_0000, 32'h0000_1000, 32'h1000_0000));
    add_tri(mk('1, '0, 48'h5555_aaaa_ffff,
               '1, 32'h0, 32'haaaa_5555));
    add_tri(mk('0, '0, '0, 32'h0000_0000, 32'h0000_1000, 32'h0000_2000));
    drain();

    write_reg(CFG_MIN_ABS_DET, 16'd0);
    write_reg(CFG_MIN_LENGTH_SQ, 16'd0);
    add_tri(mk('0, 48'h0000_0000_0001, 48'h0000_0001_0000,
               32'h0000_0000, 32'h0000_0001, 32'h0001_0000));
    add_tri(mk('0, '0, '0, 32'h0000_0000, 32'h0000_0001, 32'h0001_0000));
    random_phase(200, 1'b0);

    write_reg(CFG_MIN_ABS_DET, 16'hffff);
    write_reg(CFG_MIN_LENGTH_SQ, 16'hffff);
    add_tri(mk('0, 48'h0000_0000_0100, 48'h0000_0100_0000,
               32'h0000_0000, 32'h0000_00ff, 32'h00ff_0000));
    add_tri(mk('0, 48'h0000_0000_0100, 48'h0000_0100_0000,
               32'h0000_0000, 32'h0000_0100, 32'h0100_0000));
    add_tri(mk('0, 48'h0000_0000_0001, 48'h0000_0001_0000,
               32'h0000_0000, 32'h0000_1000, 32'h1000_0000));
    random_phase(200, 1'b0);

    write_reg(CFG_MIN_ABS_DET, 16'd4);
    write_reg(CFG_MIN_LENGTH_SQ, 16'd40);
    // long receiver stall while the sender keeps offering
    long_hold_req = 300;
    random_phase(250, 1'b1);

    write_reg(CFG_MIN_ABS_DET, 16'd1);
    write_reg(CFG_MIN_LENGTH_SQ, 16'd1);
    random_phase(200, 1'b0);

    for (int k = 0; k < 4; k++) begin
      write_reg(CFG_MIN_ABS_DET, 16'($urandom_range(0, 12)));
      write_reg(CFG_MIN_LENGTH_SQ, 16'($urandom_range(0, 80)));
      random_phase(100, k == 2);
    end

    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
